>>> sv/vector3_normalize_macros.svh
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define VN_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vector3_normalize: implication check failed");

// Next-cycle implication.
`define VN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vector3_normalize: next-cycle check failed");

`endif

>>> sv/vn_pkg.sv
`default_nettype none
package vn_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;              // component width
	localparam int QW        = FRAC_BITS + 1;   // quotient magnitude, at most 2^FRAC_BITS
	localparam int RADW      = 2 * DW;          // radicand width
	localparam int ROOTW     = RADW / 2;
	localparam int REMW      = ROOTW + 2;
	localparam int SQ_CELLS  = RADW / 2;
	localparam int DIV_CELLS = QW;
	localparam int CFG_W     = 17;

	localparam logic [CFG_W-1:0] MIN_MAG_RST = 17'd0;
	localparam logic [CFG_W-1:0] MIN_RES_RST = 17'd58982;

	typedef enum logic [1:0] {
		REG_MIN_MAG = 2'd0,
		REG_MIN_RES = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TOO_SMALL = 2'd1,
		ST_LOW_RESULT = 2'd2
	} status_t;

	typedef struct packed {
		logic                    refused;
		logic [2:0][DW-1:0]      v;
	} side_t;

	typedef struct packed {
		logic                    valid;
		logic [RADW-1:0]         rad;
		logic [REMW-1:0]         rem;
		logic [ROOTW-1:0]        root;
		side_t                   side;
	} sq_t;

	typedef struct packed {
		logic                    valid;
		logic                    refused;
		logic [DW-1:0]           m;
		logic [2:0][DW:0]        r;
		logic [2:0][QW-1:0]      q;
		logic [2:0][DW-1:0]      raw;
	} dv_t;

	function automatic logic [DW-1:0] abs_c(input logic [DW-1:0] x);
		abs_c = x[DW-1] ? (~x + 1'b1) : x;
	endfunction

endpackage
`default_nettype wire

>>> sv/vn_sqrt_cell.sv
`default_nettype none
// One radicand digit pair per cell of a digit-by-digit square root.
module vn_sqrt_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  vn_pkg::sq_t     d,
	output vn_pkg::sq_t     q
);
	logic [vn_pkg::REMW+1:0] cur;
	logic [vn_pkg::REMW+1:0] trial;
	logic                    ge;
	logic [vn_pkg::REMW+1:0] diff;

	always_comb begin
		cur   = {d.rem, d.rad[vn_pkg::RADW-1 -: 2]};
		trial = {2'b00, d.root, 2'b01};
		ge    = cur >= trial;
		diff  = ge ? (cur - trial) : cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.rad   <= {d.rad[vn_pkg::RADW-3:0], 2'b00};
			q.rem   <= diff[vn_pkg::REMW-1:0];
			q.root  <= {d.root[vn_pkg::ROOTW-2:0], ge};
			q.side  <= d.side;
		end
	end
endmodule
`default_nettype wire

>>> sv/vn_div_cell.sv
`default_nettype none
// One quotient bit for all three lanes of a restoring divide.
module vn_div_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  vn_pkg::dv_t     d,
	output vn_pkg::dv_t     q
);
	logic [2:0]              ge;
	logic [2:0][vn_pkg::DW:0] diff;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ge[i]   = d.r[i] >= {1'b0, d.m};
			diff[i] = ge[i] ? (d.r[i] - {1'b0, d.m}) : d.r[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid   <= d.valid;
			q.refused <= d.refused;
			q.m       <= d.m;
			q.raw     <= d.raw;
			for (int i = 0; i < 3; i++) begin
				// remainder stays below m, so the shift cannot lose a bit
				q.r[i] <= {diff[i][vn_pkg::DW-1:0], 1'b0};
				q.q[i] <= {d.q[i][vn_pkg::QW-2:0], ge[i]};
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/vector3_normalize.sv
// Channel   Direction  Signals                                   Transfer when
// in        input      in_valid, in_ready, in_x, in_y, in_z      in_valid & in_ready
// out       output     out_valid, out_ready, out_x/y/z, status   out_valid & out_ready
// cfg       input      cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
// One vector per cycle unless the output stalls; three input/square/sum stages, a 32-cell
// square-root chain, one compare stage, a 17-cell divide chain, two stages for the
// result's squares and sum, a second 32-cell square-root chain and the output register.
// arst_n clears the valid bits and loads the register defaults; cfg_ready is always high.
// A result held at the output stalls the whole pipeline; in_ready is low only then.
`default_nettype none
`include "vector3_normalize_macros.svh"
module vector3_normalize (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [vn_pkg::DW-1:0]  in_x,
	input  wire logic signed [vn_pkg::DW-1:0]  in_y,
	input  wire logic signed [vn_pkg::DW-1:0]  in_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [vn_pkg::DW-1:0]       out_x,
	output logic signed [vn_pkg::DW-1:0]       out_y,
	output logic signed [vn_pkg::DW-1:0]       out_z,
	output logic [1:0]                         status,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [vn_pkg::CFG_W-1:0]      cfg_data
);
	localparam int DW = vn_pkg::DW;
	localparam int QW = vn_pkg::QW;

	logic                        en;
	logic [vn_pkg::CFG_W-1:0]    min_mag_q;
	logic [vn_pkg::CFG_W-1:0]    min_res_q;

	logic                        v_s1, v_s2, v_s3, v_s5, v_s6;
	logic [2:0][DW-1:0]          raw_s1, raw_s2, raw_s3;
	logic [2:0][DW-1:0]          abs_s1;
	logic [2:0][2*DW-1:0]        sq_s2;
	logic [2*DW-1:0]             sum_s3;
	vn_pkg::sq_t                 sa [vn_pkg::SQ_CELLS+1];
	vn_pkg::dv_t                 db [vn_pkg::DIV_CELLS+1];
	vn_pkg::sq_t                 sb [vn_pkg::SQ_CELLS+1];
	logic [2:0][DW-1:0]          res_s5, res_s6;
	logic                        ref_s5, ref_s6;
	logic [2:0][2*QW-1:0]        qsq_s5;
	logic [vn_pkg::RADW-1:0]     rad_s6;
	logic                        out_valid_q;
	logic [2:0][DW-1:0]          out_q;
	vn_pkg::status_t             status_q;
	logic                        refused_c;
	vn_pkg::dv_t                 dv_init;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= vn_pkg::MIN_MAG_RST;
			min_res_q <= vn_pkg::MIN_RES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				vn_pkg::REG_MIN_MAG: min_mag_q <= cfg_data;
				vn_pkg::REG_MIN_RES: min_res_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: operands, squares, sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= {in_z, in_y, in_x};
			abs_s1 <= {vn_pkg::abs_c(in_z), vn_pkg::abs_c(in_y), vn_pkg::abs_c(in_x)};
			raw_s2 <= raw_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= {{DW{1'b0}}, abs_s1[i]} * {{DW{1'b0}}, abs_s1[i]};
			end
			raw_s3 <= raw_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	always_comb begin
		sa[0]              = '0;
		sa[0].valid        = v_s3;
		sa[0].rad          = sum_s3;
		sa[0].side.refused = 1'b0;
		sa[0].side.v       = raw_s3;
	end

	for (genvar g = 0; g < vn_pkg::SQ_CELLS; g++) begin : g_sqa
		vn_sqrt_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en), .d(sa[g]), .q(sa[g+1]));
	end

	// magnitude check, then seed the divide with |c| as the first partial remainder
	always_comb begin
		refused_c = sa[vn_pkg::SQ_CELLS].root
			<= {{(DW-vn_pkg::CFG_W){1'b0}}, min_mag_q};
		dv_init   = '0;
		for (int i = 0; i < 3; i++) begin
			dv_init.r[i] = {1'b0, vn_pkg::abs_c(sa[vn_pkg::SQ_CELLS].side.v[i])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db[0] <= '0;
		end else if (en) begin
			db[0].valid   <= sa[vn_pkg::SQ_CELLS].valid;
			db[0].refused <= refused_c;
			db[0].m       <= sa[vn_pkg::SQ_CELLS].root;
			db[0].r       <= dv_init.r;
			db[0].q       <= '0;
			db[0].raw     <= sa[vn_pkg::SQ_CELLS].side.v;
		end
	end

	for (genvar g = 0; g < vn_pkg::DIV_CELLS; g++) begin : g_div
		vn_div_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en), .d(db[g]), .q(db[g+1]));
	end

	// signed results and the squares for the recheck
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= db[vn_pkg::DIV_CELLS].valid;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ref_s5 <= db[vn_pkg::DIV_CELLS].refused;
			for (int i = 0; i < 3; i++) begin
				if (db[vn_pkg::DIV_CELLS].refused) begin
					res_s5[i] <= db[vn_pkg::DIV_CELLS].raw[i];
				end else if (db[vn_pkg::DIV_CELLS].raw[i][DW-1]) begin
					res_s5[i] <= ~{{(DW-QW){1'b0}}, db[vn_pkg::DIV_CELLS].q[i]} + 1'b1;
				end else begin
					res_s5[i] <= {{(DW-QW){1'b0}}, db[vn_pkg::DIV_CELLS].q[i]};
				end
				qsq_s5[i] <= {{QW{1'b0}}, db[vn_pkg::DIV_CELLS].q[i]}
					* {{QW{1'b0}}, db[vn_pkg::DIV_CELLS].q[i]};
			end
			ref_s6 <= ref_s5;
			res_s6 <= res_s5;
			rad_s6 <= vn_pkg::RADW'(qsq_s5[0]) + vn_pkg::RADW'(qsq_s5[1])
				+ vn_pkg::RADW'(qsq_s5[2]);
		end
	end

	always_comb begin
		sb[0]              = '0;
		sb[0].valid        = v_s6;
		sb[0].rad          = rad_s6;
		sb[0].side.refused = ref_s6;
		sb[0].side.v       = res_s6;
	end

	for (genvar g = 0; g < vn_pkg::SQ_CELLS; g++) begin : g_sqb
		vn_sqrt_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en), .d(sb[g]), .q(sb[g+1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sb[vn_pkg::SQ_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= sb[vn_pkg::SQ_CELLS].side.v;
			if (sb[vn_pkg::SQ_CELLS].side.refused) begin
				status_q <= vn_pkg::ST_TOO_SMALL;
			end else if (sb[vn_pkg::SQ_CELLS].root
					< {{(vn_pkg::ROOTW-vn_pkg::CFG_W){1'b0}}, min_res_q}) begin
				status_q <= vn_pkg::ST_LOW_RESULT;
			end else begin
				status_q <= vn_pkg::ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_q[0];
	assign out_y     = out_q[1];
	assign out_z     = out_q[2];
	assign status    = status_q;

	`VN_ASSERT_IMPL(a_status_code, out_valid, status != 2'd3)
	`VN_ASSERT_IMPL(a_unit_range, out_valid && status != vn_pkg::ST_TOO_SMALL, (out_x <= 32'sd65536 && out_x >= -32'sd65536 && out_y <= 32'sd65536 && out_y >= -32'sd65536 && out_z <= 32'sd65536 && out_z >= -32'sd65536))
	`VN_ASSERT_IMPL(a_ready_free, !out_valid, in_ready)
	`VN_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(status))
endmodule
`default_nettype wire
